>>> src/wrgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrgs_pkg
// Shared constants and types of the ripple grid block.
// ----------------------------------------------------------------------------
package wrgs_pkg;
    localparam int DefMaxWidth  = 256;
    localparam int DefMaxHeight = 256;
    localparam int CfgW         = 9;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic signed [15:0] t_height;
endpackage
`default_nettype wire

>>> src/water_ripple_grid_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// water_ripple_grid_step
// Two-buffer 2D ripple grid held in one synchronous memory.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// command | in  | i_valid / o_ready  | i_func i_col i_row i_value
// result  | out | o_valid / i_ready  | o_read_value o_waves_present
// config  | in  | i_cfg_we           | i_cfg_index i_cfg_data
//
// A write goes through states ACC and OUT to its result, a read ACC, RD, OUT.
// Step visits each interior cell as nine memory reads (eight active
// neighbours and the old cell, one read per cycle) plus one write.
// Clear returns its result right away, then sweeps the whole memory, one
// entry per cycle (131072 entries at the default size); the next command waits
// for the sweep. After reset the same sweep runs before the first command is
// taken. The result sits in an output register; the block accepts the next
// command once that register has been taken.
// ----------------------------------------------------------------------------
module water_ripple_grid_step
    import wrgs_pkg::*;
#(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_func,
    input  wire logic [7:0]          i_col,
    input  wire logic [7:0]          i_row,
    input  wire logic signed [15:0]  i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [15:0]       o_read_value,
    output logic                     o_waves_present,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [CfgW-1:0]     i_cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int DW = (CW > RW ? CW : RW) + 2;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // storage
    t_height r_mem [DEPTH];
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    t_height       m_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_waddr] <= m_wdata;
        end
        r_rdata <= r_mem[m_raddr];
    end

    logic [CfgW-1:0] r_gw, r_gh;
    logic [2:0]      r_st;
    logic            r_act, r_wave, r_found, r_ovalid;
    t_height         r_rd;
    logic [1:0]      r_func;
    logic [7:0]      r_col, r_row;
    t_height         r_val;
    logic [AW-1:0]   r_clr;
    logic [DW-1:0]   r_c, r_r;
    logic [3:0]      r_k;        // read phase within a cell
    logic            r_pend;     // read issued last cycle, data arriving
    logic [3:0]      r_pk;
    logic signed [19:0] r_sum;

    // saturated dimensions
    logic [DW-1:0] w_w, w_h;
    always_comb begin
        w_w = (32'(r_gw) > 32'(MAX_WIDTH))  ? DW'(MAX_WIDTH)  : DW'(r_gw);
        w_h = (32'(r_gh) > 32'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(r_gh);
    end

    logic w_inside;
    assign w_inside = (32'(r_col) < 32'(w_w)) && (32'(r_row) < 32'(w_h));

    // neighbour offsets for read phase k: 0..7 active neighbours, 8 old cell
    logic [DW-1:0] w_nc, w_nr;
    logic          w_ng;
    always_comb begin
        w_nc = r_c;
        w_nr = r_r;
        w_ng = r_act;
        unique case (r_k)
            4'd0: begin w_nc = r_c - 1'b1; w_nr = r_r - 1'b1; end
            4'd1: begin w_nr = r_r - 1'b1; end
            4'd2: begin w_nc = r_c + 1'b1; w_nr = r_r - 1'b1; end
            4'd3: begin w_nc = r_c - 1'b1; end
            4'd4: begin w_nc = r_c + 1'b1; end
            4'd5: begin w_nc = r_c - 1'b1; w_nr = r_r + 1'b1; end
            4'd6: begin w_nr = r_r + 1'b1; end
            4'd7: begin w_nc = r_c + 1'b1; w_nr = r_r + 1'b1; end
            default: begin w_ng = ~r_act; end
        endcase
    end

    // new cell value from sum and old cell
    t_height w_v, w_st;
    always_comb begin
        w_v  = t_height'(r_sum >>> 2) - r_rdata;
        w_st = w_v - (w_v >>> 4);
    end

    logic w_last_col, w_last_row;
    assign w_last_col = (r_c + 2'd2) >= w_w;
    assign w_last_row = (r_r + 2'd2) >= w_h;

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_clr;
        m_wdata = '0;
        m_raddr = {w_ng, w_nr[RW-1:0], w_nc[CW-1:0]};
        unique case (r_st)
            S_CLR: begin
                m_we = 1'b1;
            end
            S_ACC: begin
                m_raddr = {r_act, RW'(r_row), CW'(r_col)};
                if (r_func == FUNC_WRITE && w_inside) begin
                    m_we    = 1'b1;
                    m_waddr = {r_act, RW'(r_row), CW'(r_col)};
                    m_wdata = r_val;
                end
            end
            S_STEP: begin
                // write back once the old cell arrives
                if (r_pend && r_pk == 4'd8) begin
                    m_we    = 1'b1;
                    m_waddr = {~r_act, r_r[RW-1:0], r_c[CW-1:0]};
                    m_wdata = (w_v != 0) ? w_st : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_ready         = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid         = r_ovalid;
    assign o_read_value    = r_rd;
    assign o_waves_present = r_wave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            r_act    <= 1'b0;
            r_wave   <= 1'b0;
            r_ovalid <= 1'b0;
            r_gw     <= CfgW'(256);
            r_gh     <= CfgW'(256);
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) r_gw <= i_cfg_data;
                else                          r_gh <= i_cfg_data;
            end
            // drop the result once taken; it is never set while still held
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_func <= i_func;
                        r_col  <= i_col;
                        r_row  <= i_row;
                        r_val  <= i_value;
                        r_st   <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_rd <= '0;
                    unique case (r_func)
                        FUNC_WRITE: begin
                            if (w_inside) r_wave <= 1'b1;
                            r_st <= S_OUT;
                        end
                        FUNC_READ: r_st <= S_RD;
                        FUNC_CLEAR: begin
                            r_wave <= 1'b0;
                            r_clr  <= '0;
                            r_ovalid <= 1'b1;
                            r_st   <= S_CLR;
                        end
                        default: begin
                            r_c <= DW'(1);
                            r_r <= DW'(1);
                            r_k <= '0;
                            r_pend  <= 1'b0;
                            r_sum   <= '0;
                            r_found <= 1'b0;
                            if (w_w < DW'(3) || w_h < DW'(3)) begin
                                r_wave <= 1'b0;
                                r_act  <= ~r_act;
                                r_st   <= S_OUT;
                            end else begin
                                r_st <= S_STEP;
                            end
                        end
                    endcase
                end
                S_RD: begin
                    r_rd <= w_inside ? r_rdata : '0;
                    r_st <= S_OUT;
                end
                S_STEP: begin
                    // issue reads k=0..8; consume each read's data in the cycle after it is issued
                    r_pk <= r_k;
                    if (r_pend && r_pk == 4'd8) begin
                        if (w_v != 0) r_found <= 1'b1;
                        r_sum <= '0;
                        r_k   <= '0;
                        r_pend <= 1'b0;
                        if (w_last_row) begin
                            r_r <= DW'(1);
                            if (w_last_col) begin
                                r_wave <= r_found | (w_v != 0);
                                r_act  <= ~r_act;
                                r_st   <= S_OUT;
                            end else begin
                                r_c <= r_c + 1'b1;
                            end
                        end else begin
                            r_r <= r_r + 1'b1;
                        end
                    end else begin
                        r_pend <= (r_k <= 4'd8);
                        if (r_k <= 4'd8) r_k <= r_k + 1'b1;
                        if (r_pend) r_sum <= r_sum + 20'(r_rdata);
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // no command taken while a result waits or a sweep runs
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_st == S_IDLE)) else $error("ready outside idle");
    a_step_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_STEP) |-> (r_c >= DW'(1) && r_r >= DW'(1)))
        else $error("step cell on border");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_value)))
        else $error("result dropped");
endmodule
`default_nettype wire

>>> test/water_ripple_grid_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_ripple_grid_step_tb
// Drives ripple grid commands (write, step, read, clear) over several grid
// sizes, predicts each result from a local copy of both height grids and
// compares every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module water_ripple_grid_step_tb;
    import wrgs_pkg::*;

    localparam int GridCells  = DefMaxWidth * DefMaxHeight;
    localparam int StallLimit = 400000;  // reset/clear sweeps cover all 131072 memory entries

    typedef struct {
        t_height rd;
        logic    waves;
    } t_ripple_res;

    typedef enum logic {ROW_CMD, ROW_SIZE} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [1:0] func;
        logic [7:0] col;
        logic [7:0] row;
        t_height    value;
        bit         typed;   // expected values below are typed in
        t_height    exp_rd;
        logic       exp_waves;
        int         w;
        int         h;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_func;
    logic [7:0]          i_col;
    logic [7:0]          i_row;
    logic signed [15:0]  i_value;
    logic                o_valid;
    logic                i_ready;
    logic signed [15:0]  o_read_value;
    logic                o_waves_present;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CfgW-1:0]     i_cfg_data;

    water_ripple_grid_step uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_value   (o_read_value),
        .o_waves_present(o_waves_present),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Local copy of the block state
    t_height     heights [0:1][0:GridCells-1];
    bit          act_sel;
    logic        wave_flag;
    int          cfg_w;
    int          cfg_h;

    t_ripple_res pending_results[$];
    t_stim_row   directed[$];
    int          fail_count;
    int          results_seen;
    int          stall_cycles;
    bit          calm;          // no idling on either side
    int          clear_budget;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int used_w();
        return (cfg_w > DefMaxWidth) ? DefMaxWidth : cfg_w;
    endfunction

    function automatic int used_h();
        return (cfg_h > DefMaxHeight) ? DefMaxHeight : cfg_h;
    endfunction

    // Apply one command to the local grids and return the result beat it causes.
    task automatic ripple_apply(input logic [1:0] func, input logic [7:0] col,
                                input logic [7:0] row, input t_height value,
                                output t_ripple_res res);
        int      w;
        int      h;
        int      s;
        int      v;
        int      old_sel;
        bit      found;
        bit      in_area;
        t_height v16;
        w       = used_w();
        h       = used_h();
        in_area = (col < w) && (row < h);
        res.rd  = '0;
        case (func)
            FUNC_WRITE: begin
                if (in_area) begin
                    heights[act_sel][row * DefMaxWidth + col] = value;
                    wave_flag = 1'b1;
                end
            end
            FUNC_STEP: begin
                old_sel = !act_sel;
                found   = 1'b0;
                for (int c = 1; c + 1 < w; c++) begin
                    for (int r = 1; r + 1 < h; r++) begin
                        s = 0;
                        for (int dr = -1; dr <= 1; dr++)
                            for (int dc = -1; dc <= 1; dc++)
                                if (dr != 0 || dc != 0)
                                    s += heights[act_sel][(r + dr) * DefMaxWidth + c + dc];
                        v   = (s >>> 2) - heights[old_sel][r * DefMaxWidth + c];
                        v16 = v[15:0];
                        if (v16 != 0) begin
                            found = 1'b1;
                            v16   = v16 - (v16 >>> 4);
                        end
                        heights[old_sel][r * DefMaxWidth + c] = v16;
                    end
                end
                wave_flag = found;
                act_sel   = old_sel;
            end
            FUNC_READ: begin
                if (in_area)
                    res.rd = heights[act_sel][row * DefMaxWidth + col];
            end
            default: begin
                for (int g = 0; g < 2; g++)
                    for (int i = 0; i < GridCells; i++)
                        heights[g][i] = '0;
                wave_flag = 1'b0;
            end
        endcase
        res.waves = wave_flag;
    endtask

    // Offer one command beat, hold it until accepted, then record its result.
    task automatic send_cmd(input logic [1:0] func, input logic [7:0] col,
                            input logic [7:0] row, input t_height value,
                            input bit typed, input t_height exp_rd, input logic exp_waves);
        t_ripple_res res;
        if (!calm && $urandom_range(99) < 38) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_func  <= func;
        i_col   <= col;
        i_row   <= row;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        ripple_apply(func, col, row, value, res);
        if (typed) begin
            res.rd    = exp_rd;
            res.waves = exp_waves;
        end
        pending_results.push_back(res);
    endtask

    // Drop valid and hold until every predicted beat has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Resize only while idle: every command has a result, so a drain suffices.
    task automatic set_size(input int w, input int h);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w[CfgW-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h[CfgW-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_w = w;
        cfg_h = h;
    endtask

    task automatic add_cmd(input logic [1:0] func, input int col, input int row,
                           input int value, input bit typed = 0,
                           input int exp_rd = 0, input logic exp_waves = 0);
        t_stim_row t;
        t = '{ROW_CMD, func, col[7:0], row[7:0], value[15:0], typed,
              exp_rd[15:0], exp_waves, 0, 0};
        directed.push_back(t);
    endtask

    task automatic add_size(input int w, input int h);
        t_stim_row t;
        t = '{ROW_SIZE, FUNC_WRITE, 8'd0, 8'd0, '0, 0, '0, 1'b0, w, h};
        directed.push_back(t);
    endtask

    // Random beats within one grid size; mostly in-area cells, some anywhere.
    task automatic random_phase(input int w, input int h, input int count,
                                input int step_pct);
        int         sel;
        int         wu;
        int         hu;
        logic [1:0] func;
        logic [7:0] col;
        logic [7:0] row;
        set_size(w, h);
        wu = used_w();
        hu = used_h();
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (clear_budget > 0 && sel < 2) begin
                func = FUNC_CLEAR;
                clear_budget--;
            end else if (sel < 2 + step_pct) begin
                func = FUNC_STEP;
            end else if (sel < 60) begin
                func = FUNC_WRITE;
            end else begin
                func = FUNC_READ;
            end
            col = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(wu - 1));
            row = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(hu - 1));
            send_cmd(func, col, row, t_height'($urandom), 0, '0, 1'b0);
            if (n == count / 2 && w == 16)
                drain();
        end
    endtask

    // Check each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_ripple_res want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected (rd %0d waves %0b)",
                         $time, o_read_value, o_waves_present);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.rd) begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, want.rd, o_read_value);
                    fail_count++;
                end
                if (o_waves_present !== want.waves) begin
                    $display("%0t: waves_present expected %0b got %0b",
                             $time, want.waves, o_waves_present);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial begin
        bit held;
        held    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 40) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
        end
    end

    // Watchdog: end the run if no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_func       = FUNC_WRITE;
        i_col        = '0;
        i_row        = '0;
        i_value      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_WIDTH;
        i_cfg_data   = '0;
        fail_count   = 0;
        results_seen = 0;
        stall_cycles = 0;
        calm         = 0;
        clear_budget = 1;
        act_sel      = 0;
        wave_flag    = 1'b0;
        cfg_w        = DefMaxWidth;
        cfg_h        = DefMaxHeight;
        for (int g = 0; g < 2; g++)
            for (int i = 0; i < GridCells; i++)
                heights[g][i] = '0;

        // Directed part: corners at full size, clear, out-of-area cells,
        // steps on a small grid, tiny and oversized dimensions.
        add_cmd(FUNC_READ,    0,   0,      0, 1,      0, 1'b0);
        add_cmd(FUNC_WRITE, 255, 255, -32768, 1,      0, 1'b1);
        add_cmd(FUNC_READ,  255, 255,      0, 1, -32768, 1'b1);
        add_cmd(FUNC_WRITE,   0,   0,  32767, 1,      0, 1'b1);
        add_cmd(FUNC_READ,    0,   0,      0, 1,  32767, 1'b1);
        add_cmd(FUNC_WRITE,  17, 200, 16'h5A5A);
        add_cmd(FUNC_READ,   17, 200,      0);
        add_cmd(FUNC_CLEAR,   0,   0,      0, 1,      0, 1'b0);
        add_cmd(FUNC_READ,  255, 255,      0, 1,      0, 1'b0);
        add_size(5, 4);
        add_cmd(FUNC_WRITE,   5,   0,    100, 1,      0, 1'b0);
        add_cmd(FUNC_READ,    0,   4,      0, 1,      0, 1'b0);
        add_cmd(FUNC_WRITE,   2,   1,   1000);
        add_cmd(FUNC_WRITE,   1,   2,  -1000);
        add_cmd(FUNC_STEP,    0,   0,      0);
        add_cmd(FUNC_STEP,    0,   0,      0);
        add_cmd(FUNC_READ,    2,   1,      0);
        add_cmd(FUNC_READ,    3,   2,      0);
        add_size(2, 9);
        add_cmd(FUNC_STEP,    0,   0,      0, 1,      0, 1'b0);
        add_size(511, 3);
        add_cmd(FUNC_WRITE, 255,   1,   -300);
        add_cmd(FUNC_STEP,    0,   0,      0);
        add_size(3, 256);
        add_cmd(FUNC_STEP,    0,   0,      0);
        add_cmd(FUNC_READ,    1, 255,      0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_SIZE)
                set_size(directed[k].w, directed[k].h);
            else
                send_cmd(directed[k].func, directed[k].col, directed[k].row,
                         directed[k].value, directed[k].typed,
                         directed[k].exp_rd, directed[k].exp_waves);
        end

        // Random part over several sizes; one phase runs with no idling.
        random_phase(8, 8, 20, 20);
        random_phase(3, 256, 16, 15);
        calm = 1;
        random_phase(511, 5, 16, 12);
        calm = 0;
        random_phase(16, 12, 26, 18);
        random_phase(6, 6, 22, 25);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> files.f
src/wrgs_pkg.sv
src/water_ripple_grid_step.sv
test/water_ripple_grid_step_tb.sv
